>>> rtl/abc_pkg.sv
// Package for the archive block cipher: shared types, constants and the
// mixing table generator. Used by every module under rtl/ but abc_ram.
package abc_pkg;

  localparam logic [31:0] SEED_INIT = 32'hEEEE_EEEE;
  localparam logic [31:0] KEY_ADD   = 32'h1111_1111;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableAddrW = 8;

  // generator constants for the mixing table
  localparam longint unsigned GenStart = 64'h10_0001;
  localparam longint unsigned GenMod   = 64'h2A_AAAB;
  localparam longint unsigned GenMul   = 64'd125;
  localparam int unsigned     GenRows  = 5;
  localparam int unsigned     TableRow = 4;

  typedef logic [31:0] mix_table_t [TableDepth];

  // one word held between the key stage and the mix stage
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] key;
    logic        dir;
    logic        first;
    logic        last;
  } abc_s1_t;

  // builds the 256-word table slice; evaluated at elaboration only
  function automatic mix_table_t gen_mix_table();
    mix_table_t      tbl;
    longint unsigned s;
    longint unsigned a;
    longint unsigned b;
    s = GenStart;
    for (int col = 0; col < TableDepth; col++) begin
      for (int row = 0; row < GenRows; row++) begin
        a = (GenMul * s + 64'd3) % GenMod;
        b = (GenMul * a + 64'd3) % GenMod;
        if (row == TableRow) begin
          tbl[col] = {a[15:0], b[15:0]};
        end
        s = b;
      end
    end
    return tbl;
  endfunction

  localparam mix_table_t MIX_TABLE = gen_mix_table();

  // key schedule step: rotate-and-mix for the next word
  function automatic logic [31:0] next_key(input logic [31:0] k);
    logic [31:0] hi;
    hi = (~k << 21) + KEY_ADD;
    return (k >> 11) | hi;
  endfunction

endpackage

>>> rtl/abc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module abc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/abc_key_stage.sv
// First pipeline stage: takes input transactions, selects the block key,
// advances the key schedule and addresses the mixing table RAM.
// Depends on abc_pkg.
module abc_key_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     in_word,
  input  logic [31:0]                     in_key,
  input  logic                            in_first,
  input  logic                            in_dir,
  input  logic                            in_last,
  input  logic                            fill_busy,
  input  logic                            s1_ready,
  output logic                            s1_valid,
  output abc_pkg::abc_s1_t                s1,
  output logic [abc_pkg::TableAddrW-1:0]  rd_addr
);
  import abc_pkg::*;

  logic [31:0] running_key;
  logic        direction;
  logic [31:0] key_used;
  logic        dir_used;
  logic        accept;

  // stage is free when empty or when its word moves on this cycle, never during the table load
  assign in_ready = !fill_busy && (!s1_valid || s1_ready);
  assign accept   = in_valid && in_ready;

  // a block start loads the key and direction
  assign key_used = in_first ? in_key : running_key;
  assign dir_used = in_first ? in_dir : direction;

  // keep the table address of the held word while stalled
  assign rd_addr = accept ? key_used[TableAddrW-1:0] : s1.key[TableAddrW-1:0];

  // running key and direction
  always_ff @(posedge clk) begin
    if (rst) begin
      running_key <= '0;
      direction   <= 1'b0;
    end else if (accept) begin
      running_key <= next_key(key_used);
      direction   <= dir_used;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.word  <= in_word;
      s1.key   <= key_used;
      s1.dir   <= dir_used;
      s1.first <= in_first;
      s1.last  <= in_last;
    end
  end

endmodule

>>> rtl/abc_mix_stage.sv
// Second pipeline stage: adds the table word to the running seed, forms the
// output word, updates the seed and holds the result register.
// Depends on abc_pkg.
module abc_mix_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             s1_valid,
  output logic             s1_ready,
  input  abc_pkg::abc_s1_t s1,
  input  logic [31:0]      table_word,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_word,
  output logic             out_last
);
  import abc_pkg::*;

  logic [31:0] running_seed;
  logic [31:0] seed_used;
  logic [31:0] mix;
  logic [31:0] res;
  logic [31:0] plain;
  logic [31:0] seed_next;
  logic        advance;

  assign s1_ready = !out_valid || out_ready;
  assign advance  = s1_valid && s1_ready;

  // cipher arithmetic for the word in stage 1
  assign seed_used = s1.first ? SEED_INIT : running_seed;
  assign mix       = table_word + seed_used;
  assign res       = s1.word ^ (s1.key + mix);
  assign plain     = s1.dir ? res : s1.word;
  assign seed_next = plain + (mix << 5) + mix + 32'd3;

  // running seed
  always_ff @(posedge clk) begin
    if (rst) begin
      running_seed <= SEED_INIT;
    end else if (advance) begin
      running_seed <= seed_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res;
      out_last <= s1.last;
    end
  end

endmodule

>>> rtl/archive_block_cipher.sv
// Archive block cipher, streaming one 32-bit word per transaction. The mixing
// table sits in a 256 x 32 RAM that is loaded after reset in a pass
// during which s_axis_tready stays low. After that the block takes one word
// every cycle unless the output stalls: a word passes the key stage with the
// table read, then the mix stage and output register. The seed chain in the mix
// stage sets that one-word-per-cycle figure. Set tuser[0] on the first word of
// a block to load the key from tdata[63:32] and the direction from tuser[1].
// Depends on abc_pkg, abc_ram, abc_key_stage and abc_mix_stage.
module archive_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // data_word [31:0], block_key [63:32]
  input  logic [1:0]  s_axis_tuser,  // first_word [0], decrypt_mode [1]
  input  logic        s_axis_tlast,  // last_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_word [31:0]
  output logic        m_axis_tlast   // result_last
);
  import abc_pkg::*;

  logic [TableAddrW:0]   fill_cnt;
  logic                  fill_busy;
  logic [TableAddrW-1:0] rd_addr;
  logic [31:0]           table_word;
  logic                  s1_valid;
  logic                  s1_ready;
  abc_s1_t               s1;

  // table load pass after reset
  assign fill_busy = !fill_cnt[TableAddrW];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else if (fill_busy) begin
      fill_cnt <= fill_cnt + 1'b1;
    end
  end

  // mixing table
  abc_ram #(
    .WIDTH (32),
    .DEPTH (TableDepth)
  ) u_table (
    .clk     (clk),
    .wr_en   (fill_busy),
    .wr_addr (fill_cnt[TableAddrW-1:0]),
    .wr_data (MIX_TABLE[fill_cnt[TableAddrW-1:0]]),
    .rd_addr (rd_addr),
    .rd_data (table_word)
  );

  // key schedule and table addressing
  abc_key_stage u_key (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_word   (s_axis_tdata[31:0]),
    .in_key    (s_axis_tdata[63:32]),
    .in_first  (s_axis_tuser[0]),
    .in_dir    (s_axis_tuser[1]),
    .in_last   (s_axis_tlast),
    .fill_busy (fill_busy),
    .s1_ready  (s1_ready),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .rd_addr   (rd_addr)
  );

  // seed chain and output register
  abc_mix_stage u_mix (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1         (s1),
    .table_word (table_word),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_word   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

>>> tb/archive_block_cipher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for archive_block_cipher: a local model of the word cipher predicts
// each output word, with bursty input traffic and a stalling output sink. Needs only the RTL.
module archive_block_cipher_tb;

  localparam logic [31:0] SEED_START = 32'hEEEE_EEEE;
  localparam logic [31:0] KEY_STEP   = 32'h1111_1111;

  // mixing table generator
  localparam longint unsigned GEN_SEED    = 64'h10_0001;
  localparam longint unsigned GEN_MODULUS = 64'h2A_AAAB;
  localparam longint unsigned GEN_FACTOR  = 64'd125;
  localparam int unsigned     GEN_ROWS    = 5;
  localparam int unsigned     GEN_PICK    = 4;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned STALL_CYCLES = 400;

  typedef enum logic [2:0] {
    SINK_FLOW,
    SINK_COIN,
    SINK_LIGHT,
    SINK_PERIODIC,
    SINK_HEAVY
  } sink_mode_e;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } cipher_out_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // data_word [31:0], block_key [63:32]
  logic [1:0]  s_axis_tuser;   // first_word [0], decrypt_mode [1]
  logic        s_axis_tlast;   // last_word
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // result_word [31:0]
  logic        m_axis_tlast;   // result_last

  // cipher model state
  logic [31:0] mix_tbl [256];
  logic [31:0] cipher_key;
  logic [31:0] cipher_seed;
  logic        cipher_dir;
  logic [31:0] last_cipher;
  cipher_out_t cipher_out_q [$];

  int unsigned burst_left;
  bit          steady_source;
  int unsigned sink_hold;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned blocks_started;

  archive_block_cipher dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, cipher_out_q.size());
      $display("archive_block_cipher_tb: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // table slice picked from the fifth generator row of each column
  function automatic void build_mix_table();
    longint unsigned s;
    longint unsigned a;
    longint unsigned b;
    s = GEN_SEED;
    for (int col = 0; col < 256; col++) begin
      for (int row = 0; row < GEN_ROWS; row++) begin
        a = (GEN_FACTOR * s + 64'd3) % GEN_MODULUS;
        b = (GEN_FACTOR * a + 64'd3) % GEN_MODULUS;
        if (row == GEN_PICK) begin
          mix_tbl[col] = {a[15:0], b[15:0]};
        end
        s = b;
      end
    end
  endfunction

  // advance the cipher model by one word and queue the word it should produce
  function automatic logic [31:0] cipher_predict(input logic [31:0] word, input logic first,
                                                 input logic [31:0] key, input logic dec,
                                                 input logic last);
    logic [31:0] mix;
    logic [31:0] res;
    logic [31:0] plain;
    cipher_out_t item;
    if (first) begin
      cipher_key  = key;
      cipher_dir  = dec;
      cipher_seed = SEED_START;
    end
    mix   = mix_tbl[cipher_key[7:0]] + cipher_seed;
    res   = word ^ (cipher_key + mix);
    plain = cipher_dir ? res : word;
    cipher_seed = plain + 32'd33 * mix + 32'd3;
    cipher_key  = (cipher_key >> 11) | ((~cipher_key << 21) + KEY_STEP);
    item.word = res;
    item.last = last;
    cipher_out_q.push_back(item);
    return res;
  endfunction

  // offer one word, with random gaps between bursts; returns after the transaction
  task automatic send_word(input logic [31:0] word, input logic first,
                           input logic [31:0] key, input logic dec, input logic last);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (!steady_source && $urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 12);
      end
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) begin
          s_axis_tdata = {$urandom, $urandom};
          s_axis_tuser = 2'($urandom_range(0, 3));
          s_axis_tlast = 1'($urandom_range(0, 1));
          @(negedge clk);
        end
      end
    end
    burst_left--;
    s_axis_tdata  = {key, word};
    s_axis_tuser  = {dec, first};
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    last_cipher = cipher_predict(word, first, key, dec, last);
    words_sent++;
    if (first) blocks_started++;
  endtask

  // keys biased toward table corners and all-zero / all-one values
  function automatic logic [31:0] rand_block_key();
    logic [31:0] k;
    k = $urandom;
    case ($urandom_range(0, 9))
      0: k[7:0] = 8'h00;
      1: k[7:0] = 8'hFF;
      2: k = '0;
      3: k = '1;
      default: ;
    endcase
    return k;
  endfunction

  // output sink: stall pattern is redrawn at random from five modes
  initial begin : sink
    sink_mode_e  mode;
    int unsigned mode_left;
    mode          = SINK_FLOW;
    mode_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 4));
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      if (sink_hold != 0) begin
        m_axis_tready = 1'b0;
        sink_hold--;
      end else begin
        case (mode)
          SINK_FLOW:     m_axis_tready = 1'b1;
          SINK_COIN:     m_axis_tready = 1'($urandom_range(0, 1));
          SINK_LIGHT:    m_axis_tready = ($urandom_range(0, 7) != 0);
          SINK_PERIODIC: m_axis_tready = (cycle_count % 4 != 0);
          default:       m_axis_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result checker: oldest expectation against each output transaction
  always @(posedge clk) begin : result_check
    cipher_out_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      results_seen++;
      if (cipher_out_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", m_axis_tdata));
      end else begin
        want = cipher_out_q.pop_front();
        if (m_axis_tdata !== want.word) begin
          report_mismatch($sformatf("result %0d word %h, want %h",
                                    results_seen, m_axis_tdata, want.word));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch($sformatf("result %0d last %b, want %b",
                                    results_seen, m_axis_tlast, want.last));
        end
      end
    end
  end

  // words right after reset, and after a last mark, run on the current state;
  // key and direction fields are set but must be ignored
  task automatic test_start_without_block();
    send_word($urandom, 1'b0, $urandom, 1'b1, 1'b0);
    send_word($urandom, 1'b0, $urandom, 1'b1, 1'b1);
    send_word($urandom, 1'b0, $urandom, 1'b0, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_word(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FF00, 1'b1, 1'b0);
    send_word(32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b1);
    send_word(32'h0000_0000, 1'b1, 32'h0000_00FF, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1, 32'h8000_0001, 1'b0, 1'b1);
  endtask

  // mid-block key and direction fields differ from the block start
  task automatic test_ignored_key();
    logic dec;
    dec = 1'($urandom_range(0, 1));
    send_word($urandom, 1'b1, rand_block_key(), dec, 1'b0);
    for (int i = 0; i < 3; i++) begin
      send_word($urandom, 1'b0, $urandom, ~dec, i == 2);
    end
  endtask

  // encrypt a block, then decrypt the predicted ciphertext with the same key
  task automatic test_decrypt_roundtrip();
    logic [31:0] ciph [4];
    logic [31:0] key;
    key = $urandom;
    for (int i = 0; i < 4; i++) begin
      send_word($urandom, i == 0, key, 1'b0, i == 3);
      ciph[i] = last_cipher;
    end
    for (int i = 0; i < 4; i++) begin
      send_word(ciph[i], i == 0, key, 1'b1, i == 3);
    end
  endtask

  // mostly well-formed blocks, with stray words and blocks broken off early
  task automatic test_random_blocks(input int unsigned n_items);
    int unsigned done;
    int unsigned len;
    int unsigned pick;
    int unsigned stop;
    logic [31:0] key;
    logic        dec;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      key  = rand_block_key();
      dec  = 1'($urandom_range(0, 1));
      if (pick < 80) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_word($urandom, i == 0, (i == 0) ? key : $urandom,
                    (i == 0) ? dec : logic'($urandom_range(0, 1)), i == len - 1);
        end
      end else if (pick < 90) begin
        len = 1;
        send_word($urandom, 1'b0, $urandom, dec, 1'($urandom_range(0, 1)));
      end else begin
        // last mark misplaced or missing
        len  = $urandom_range(2, 8);
        stop = $urandom_range(0, len);
        for (int i = 0; i < len; i++) begin
          send_word($urandom, i == 0, key, dec, i == stop);
        end
      end
      done += len;
    end
  endtask

  // sink holds off for a long stretch while the source keeps offering words
  task automatic test_output_stall(input int unsigned n_items);
    steady_source = 1'b1;
    sink_hold     = STALL_CYCLES;
    for (int i = 0; i < n_items; i++) begin
      send_word($urandom, i % 10 == 0, rand_block_key(), 1'($urandom_range(0, 1)),
                i % 10 == 9);
    end
    steady_source = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    s_axis_tlast   = 1'b0;
    cipher_key     = '0;
    cipher_seed    = SEED_START;
    cipher_dir     = 1'b0;
    last_cipher    = '0;
    burst_left     = 0;
    steady_source  = 1'b0;
    sink_hold      = 0;
    cycle_count    = 0;
    error_count    = 0;
    words_sent     = 0;
    results_seen   = 0;
    blocks_started = 0;
    build_mix_table();
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    test_start_without_block();
    test_field_extremes();
    test_ignored_key();
    test_decrypt_roundtrip();
    test_random_blocks(470);
    test_output_stall(60);

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (cipher_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cipher_out_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", cipher_out_q.size()));
    end

    $display("summary: %0d words in %0d keyed blocks, %0d results checked, %0d cycles",
             words_sent, blocks_started, results_seen, cycle_count);
    $display("summary: both directions, stray and broken blocks, %0d-cycle sink stall",
             STALL_CYCLES);
    if (error_count == 0) begin
      $display("archive_block_cipher_tb: clean");
    end else begin
      $display("archive_block_cipher_tb: errors");
    end
    $finish;
  end

endmodule

>>> archive_block_cipher.f
rtl/abc_pkg.sv
rtl/abc_ram.sv
rtl/abc_key_stage.sv
rtl/abc_mix_stage.sv
rtl/archive_block_cipher.sv
tb/archive_block_cipher_tb.sv
